### rtl/core/ld_pkg.sv
// ld_pkg: shared types, register indexes and reset values for the landing detector.
// No dependencies; used by rtl/core/landing_detector.sv.
package ld_pkg;

   localparam int CHECK_INTERVAL_MS_DEF = 1000;
   localparam int COUNTER_WIDTH_DEF     = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [1:0] {
      OUTCOME_FALLING = 2'd0,
      OUTCOME_LANDED  = 2'd1,
      OUTCOME_TIMEOUT = 2'd2
   } outcome_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GYRO_THRESHOLD      = 3'd0,
      CSR_GYRO_COUNT_TARGET   = 3'd1,
      CSR_PRES_DELTA_THRESH   = 3'd2,
      CSR_PRES_COUNT_TARGET   = 3'd3,
      CSR_PULSE_THRESHOLD     = 3'd4,
      CSR_PULSE_COUNT_TARGET  = 3'd5,
      CSR_ABORT_TIME_MS       = 3'd6
   } csr_index_type;

   localparam logic [10:0] GYRO_THRESHOLD_RST      = 11'd5;
   localparam logic [7:0]  GYRO_COUNT_TARGET_RST   = 8'd5;
   localparam logic [10:0] PRES_DELTA_THRESH_RST   = 11'd1;
   localparam logic [7:0]  PRES_COUNT_TARGET_RST   = 8'd5;
   localparam logic [15:0] PULSE_THRESHOLD_RST     = 16'd1000;
   localparam logic [7:0]  PULSE_COUNT_TARGET_RST  = 8'd5;
   localparam logic [31:0] ABORT_TIME_MS_RST       = 32'd600000;

   // Magnitude of a 12-bit signed rate; -2048 gives 2048 in 12 unsigned bits.
   function automatic logic [11:0] mag12(input logic signed [11:0] v);
      logic [11:0] r;
      r = v[11] ? (12'd0 - 12'(v)) : 12'(v);
      return r;
   endfunction

endpackage

### rtl/core/landing_detector.sv
// landing_detector: per-tick landing / timeout decision from gyro, pressure and encoders.
// Depends on rtl/core/ld_pkg.sv.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------------
//   req     | in        | req_valid / req_ready | begin_req, now_ms, gyro xyz, pressure,
//           |           |                       | pulse_left, pulse_right
//   rsp     | out       | rsp_valid / rsp_ready | outcome, checked, three counters
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// One item per cycle sustained while rsp is not stalled; an item's result is valid on
// rsp once it has gone from the input register, through one pass of compares/subtracts,
// into the result register. Detector state updates on that move, so the next item sees
// it immediately. A stalled rsp holds its result; req stays ready while the input register
// is empty or moving. Reset clears the state and loads register defaults.
module landing_detector #(
   parameter int CHECK_INTERVAL_MS = ld_pkg::CHECK_INTERVAL_MS_DEF,
   parameter int COUNTER_WIDTH     = ld_pkg::COUNTER_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_begin_req,
   input  logic [31:0]                    req_now_ms,
   input  logic signed [11:0]             req_gyro_x,
   input  logic signed [11:0]             req_gyro_y,
   input  logic signed [11:0]             req_gyro_z,
   input  logic [10:0]                    req_pressure,
   input  logic signed [31:0]             req_pulse_left,
   input  logic signed [31:0]             req_pulse_right,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_outcome,
   output logic                           rsp_checked,
   output logic [7:0]                     rsp_pressure_count,
   output logic [7:0]                     rsp_gyro_count,
   output logic [7:0]                     rsp_pulse_count,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ld_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ld_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int CW   = COUNTER_WIDTH;
   localparam int CMPW = (CW > 8) ? CW : 8;
   localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

   // Saturating count: clears when the condition fails, stops at min(target, CNT_MAX).
   function automatic logic [CW-1:0] bump(input logic [CW-1:0] cnt,
                                          input logic [7:0]    target,
                                          input logic          cond);
      logic [CMPW-1:0] cap;
      logic [CMPW-1:0] c;
      logic [CW-1:0]   r;
      cap = (CMPW'(target) < CMPW'(CNT_MAX)) ? CMPW'(target) : CMPW'(CNT_MAX);
      c   = CMPW'(cnt);
      if (!cond)
         r = '0;
      else if (c < cap)
         r = cnt + CW'(1);
      else
         r = cnt;
      return r;
   endfunction

   function automatic logic reached(input logic [CW-1:0] cnt, input logic [7:0] target);
      return CMPW'(cnt) >= CMPW'(target);
   endfunction

   function automatic logic [7:0] to_out(input logic [CW-1:0] cnt);
      logic [CMPW-1:0] e;
      e = CMPW'(cnt);
      return e[7:0];
   endfunction

   // configuration
   logic [10:0] gyro_thr_ff;
   logic [7:0]  gyro_tgt_ff;
   logic [10:0] pres_thr_ff;
   logic [7:0]  pres_tgt_ff;
   logic [15:0] pulse_thr_ff;
   logic [7:0]  pulse_tgt_ff;
   logic [31:0] abort_ff;

   // input register
   logic               s1_valid_ff;
   logic               s1_begin_ff;
   logic [31:0]        s1_now_ff;
   logic signed [11:0] s1_gx_ff, s1_gy_ff, s1_gz_ff;
   logic [10:0]        s1_pres_ff;
   logic [31:0]        s1_left_ff, s1_right_ff;

   // detector state
   logic [31:0]   start_ff, start_in;
   logic [31:0]   last_chk_ff, last_chk_in;
   logic [10:0]   prev_pres_ff, prev_pres_in;
   logic [31:0]   prev_left_ff, prev_left_in;
   logic [31:0]   prev_right_ff, prev_right_in;
   logic [CW-1:0] steady_ff, steady_in;
   logic [CW-1:0] calm_ff, calm_in;
   logic [CW-1:0] moving_ff, moving_in;

   // result register
   logic                rsp_valid_ff;
   ld_pkg::outcome_type outcome_ff, outcome_in;
   logic                checked_ff, checked_in;
   logic [7:0]          pcnt_ff, gcnt_ff, mcnt_ff;

   logic advance;

   // per-tick datapath
   logic        calm_ok;
   logic [10:0] pres_base;
   logic [10:0] dp;
   logic        due;
   logic signed [32:0] dl, dr;
   logic [32:0] adl, adr;
   logic        moving_ok;
   logic [CW-1:0] steady_nx, moving_nx;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_comb begin
      calm_ok = (ld_pkg::mag12(s1_gx_ff) < 12'(gyro_thr_ff)) &&
                (ld_pkg::mag12(s1_gy_ff) < 12'(gyro_thr_ff)) &&
                (ld_pkg::mag12(s1_gz_ff) < 12'(gyro_thr_ff));

      // an empty previous pressure takes the current sample
      pres_base = (prev_pres_ff == 11'd0) ? s1_pres_ff : prev_pres_ff;
      dp = (s1_pres_ff > pres_base) ? (s1_pres_ff - pres_base) : (pres_base - s1_pres_ff);

      due = (s1_now_ff - last_chk_ff) >= 32'(CHECK_INTERVAL_MS);

      dl  = $signed({s1_left_ff[31], s1_left_ff}) - $signed({prev_left_ff[31], prev_left_ff});
      dr  = $signed({s1_right_ff[31], s1_right_ff})
            - $signed({prev_right_ff[31], prev_right_ff});
      adl = dl[32] ? (33'd0 - 33'(dl)) : 33'(dl);
      adr = dr[32] ? (33'd0 - 33'(dr)) : 33'(dr);
      moving_ok = (adl > 33'(pulse_thr_ff)) && (adr > 33'(pulse_thr_ff));

      steady_nx = bump(steady_ff, pres_tgt_ff, dp < pres_thr_ff);
      moving_nx = bump(moving_ff, pulse_tgt_ff, moving_ok);

      start_in      = start_ff;
      last_chk_in   = last_chk_ff;
      prev_pres_in  = prev_pres_ff;
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      steady_in     = steady_ff;
      calm_in       = calm_ff;
      moving_in     = moving_ff;
      outcome_in    = ld_pkg::OUTCOME_FALLING;
      checked_in    = 1'b0;

      if (s1_begin_ff) begin
         start_in     = s1_now_ff;
         last_chk_in  = s1_now_ff;
         prev_pres_in = '0;
         steady_in    = '0;
         calm_in      = '0;
      end else begin
         prev_pres_in = pres_base;
         calm_in      = bump(calm_ff, gyro_tgt_ff, calm_ok);
         if (due) begin
            checked_in    = 1'b1;
            last_chk_in   = s1_now_ff;
            steady_in     = steady_nx;
            prev_pres_in  = s1_pres_ff;
            moving_in     = moving_nx;
            prev_left_in  = s1_left_ff;
            prev_right_in = s1_right_ff;
            // landing wins over timeout
            if (reached(steady_nx, pres_tgt_ff) &&
                (reached(calm_in, gyro_tgt_ff) || reached(moving_nx, pulse_tgt_ff)))
               outcome_in = ld_pkg::OUTCOME_LANDED;
            else if ((s1_now_ff - start_ff) > abort_ff)
               outcome_in = ld_pkg::OUTCOME_TIMEOUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_thr_ff  <= ld_pkg::GYRO_THRESHOLD_RST;
         gyro_tgt_ff  <= ld_pkg::GYRO_COUNT_TARGET_RST;
         pres_thr_ff  <= ld_pkg::PRES_DELTA_THRESH_RST;
         pres_tgt_ff  <= ld_pkg::PRES_COUNT_TARGET_RST;
         pulse_thr_ff <= ld_pkg::PULSE_THRESHOLD_RST;
         pulse_tgt_ff <= ld_pkg::PULSE_COUNT_TARGET_RST;
         abort_ff     <= ld_pkg::ABORT_TIME_MS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ld_pkg::CSR_GYRO_THRESHOLD:     gyro_thr_ff  <= csr_data[10:0];
            ld_pkg::CSR_GYRO_COUNT_TARGET:  gyro_tgt_ff  <= csr_data[7:0];
            ld_pkg::CSR_PRES_DELTA_THRESH:  pres_thr_ff  <= csr_data[10:0];
            ld_pkg::CSR_PRES_COUNT_TARGET:  pres_tgt_ff  <= csr_data[7:0];
            ld_pkg::CSR_PULSE_THRESHOLD:    pulse_thr_ff <= csr_data[15:0];
            ld_pkg::CSR_PULSE_COUNT_TARGET: pulse_tgt_ff <= csr_data[7:0];
            ld_pkg::CSR_ABORT_TIME_MS:      abort_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_begin_ff <= req_begin_req;
         s1_now_ff   <= req_now_ms;
         s1_gx_ff    <= req_gyro_x;
         s1_gy_ff    <= req_gyro_y;
         s1_gz_ff    <= req_gyro_z;
         s1_pres_ff  <= req_pressure;
         s1_left_ff  <= req_pulse_left;
         s1_right_ff <= req_pulse_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff      <= '0;
         last_chk_ff   <= '0;
         prev_pres_ff  <= '0;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         steady_ff     <= '0;
         calm_ff       <= '0;
         moving_ff     <= '0;
      end else if (advance) begin
         start_ff      <= start_in;
         last_chk_ff   <= last_chk_in;
         prev_pres_ff  <= prev_pres_in;
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         steady_ff     <= steady_in;
         calm_ff       <= calm_in;
         moving_ff     <= moving_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         outcome_ff <= outcome_in;
         checked_ff <= checked_in;
         pcnt_ff    <= to_out(steady_in);
         gcnt_ff    <= to_out(calm_in);
         mcnt_ff    <= to_out(moving_in);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_outcome        = outcome_ff;
   assign rsp_checked        = checked_ff;
   assign rsp_pressure_count = pcnt_ff;
   assign rsp_gyro_count     = gcnt_ff;
   assign rsp_pulse_count    = mcnt_ff;

`ifndef ASSERT_OFF
   // a decision is only ever made on a check tick
   a_outcome_needs_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome != ld_pkg::OUTCOME_FALLING) |-> rsp_checked)
      else $error("outcome reported on a tick without a check");

   // a begin item leaves the pressure and gyro counters cleared
   a_begin_clears: assert property (@(posedge clock) disable iff (reset)
      advance && s1_begin_ff |=> (steady_ff == '0) && (calm_ff == '0))
      else $error("begin item did not clear counters");

   // a checked item moves the check time to its own timestamp
   a_check_time: assert property (@(posedge clock) disable iff (reset)
      advance && checked_in |=> last_chk_ff == $past(s1_now_ff))
      else $error("check time not updated");

   // no bubble: a draining output always leaves room for a new item
   a_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");
`endif

endmodule

### bench/tb_landing_detector.sv
// tb_landing_detector: self-checking testbench for landing_detector.
// Holds a scoreboard class that predicts every tick result, plus plain driver tasks.
// Depends on rtl/core/ld_pkg.sv and rtl/core/landing_detector.sv.
`timescale 1ns / 100ps

module tb_landing_detector;

   localparam int CHECK_MS = ld_pkg::CHECK_INTERVAL_MS_DEF;
   localparam int SAT_MAX  = (1 << ld_pkg::COUNTER_WIDTH_DEF) - 1;

   typedef struct {
      logic               begin_req;
      logic [31:0]        now_ms;
      logic signed [11:0] gyro_x;
      logic signed [11:0] gyro_y;
      logic signed [11:0] gyro_z;
      logic [10:0]        pressure;
      logic signed [31:0] pulse_left;
      logic signed [31:0] pulse_right;
   } tick_type;

   typedef struct {
      ld_pkg::outcome_type outcome;
      logic                checked;
      logic [7:0]          pressure_count;
      logic [7:0]          gyro_count;
      logic [7:0]          pulse_count;
   } verdict_type;

   typedef enum {
      PROF_DEFAULT, PROF_FLOOR, PROF_CEILING, PROF_REALISTIC, PROF_LOWERED, PROF_ANY
   } profile_type;

   class scoreboard_type;
      int          gyro_thr, gyro_tgt, pres_thr, pres_tgt, pulse_thr, pulse_tgt;
      logic [31:0] abort_ms;
      logic [31:0] start_ms, last_check_ms;
      int          prev_pres;
      logic signed [31:0] prev_left, prev_right;
      int          steady_cnt, calm_cnt, moving_cnt;
      verdict_type verdict_q[$];
      int          errors;

      function new();
         gyro_thr  = ld_pkg::GYRO_THRESHOLD_RST;
         gyro_tgt  = ld_pkg::GYRO_COUNT_TARGET_RST;
         pres_thr  = ld_pkg::PRES_DELTA_THRESH_RST;
         pres_tgt  = ld_pkg::PRES_COUNT_TARGET_RST;
         pulse_thr = ld_pkg::PULSE_THRESHOLD_RST;
         pulse_tgt = ld_pkg::PULSE_COUNT_TARGET_RST;
         abort_ms  = ld_pkg::ABORT_TIME_MS_RST;
         start_ms = '0;
         last_check_ms = '0;
         prev_pres = 0;
         prev_left = '0;
         prev_right = '0;
         steady_cnt = 0;
         calm_cnt = 0;
         moving_cnt = 0;
         errors = 0;
      endfunction

      function void write_reg(ld_pkg::csr_index_type idx, logic [31:0] value);
         unique case (idx)
            ld_pkg::CSR_GYRO_THRESHOLD:     gyro_thr  = value[10:0];
            ld_pkg::CSR_GYRO_COUNT_TARGET:  gyro_tgt  = value[7:0];
            ld_pkg::CSR_PRES_DELTA_THRESH:  pres_thr  = value[10:0];
            ld_pkg::CSR_PRES_COUNT_TARGET:  pres_tgt  = value[7:0];
            ld_pkg::CSR_PULSE_THRESHOLD:    pulse_thr = value[15:0];
            ld_pkg::CSR_PULSE_COUNT_TARGET: pulse_tgt = value[7:0];
            ld_pkg::CSR_ABORT_TIME_MS:      abort_ms  = value;
            default: ;
         endcase
      endfunction

      function int rate_mag(logic signed [11:0] rate);
         int r;
         r = rate;
         return (r < 0) ? -r : r;
      endfunction

      // counter above a lowered cap is held, not pulled down
      function int sat_step(int cnt, int target, bit cond);
         int cap;
         cap = (target < SAT_MAX) ? target : SAT_MAX;
         if (!cond) return 0;
         if (cnt < cap) cnt++;
         return cnt & SAT_MAX;
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction

      function void note_tick(tick_type t);
         verdict_type v;
         logic [31:0] since_check, since_start;
         int          pres_delta;
         longint      dl, dr;
         bit          calm, moving;
         v.outcome = ld_pkg::OUTCOME_FALLING;
         v.checked = 1'b0;
         if (t.begin_req) begin
            start_ms = t.now_ms;
            last_check_ms = t.now_ms;
            prev_pres = 0;
            steady_cnt = 0;
            calm_cnt = 0;
         end else begin
            if (prev_pres == 0) prev_pres = t.pressure;
            calm = rate_mag(t.gyro_x) < gyro_thr && rate_mag(t.gyro_y) < gyro_thr &&
                   rate_mag(t.gyro_z) < gyro_thr;
            calm_cnt = sat_step(calm_cnt, gyro_tgt, calm);
            since_check = t.now_ms - last_check_ms;
            if (since_check >= CHECK_MS) begin
               v.checked = 1'b1;
               last_check_ms = t.now_ms;
               pres_delta = int'(t.pressure) - prev_pres;
               if (pres_delta < 0) pres_delta = -pres_delta;
               steady_cnt = sat_step(steady_cnt, pres_tgt, pres_delta < pres_thr);
               prev_pres = t.pressure;
               dl = longint'(t.pulse_left) - longint'(prev_left);
               dr = longint'(t.pulse_right) - longint'(prev_right);
               if (dl < 0) dl = -dl;
               if (dr < 0) dr = -dr;
               moving = dl > longint'(pulse_thr) && dr > longint'(pulse_thr);
               moving_cnt = sat_step(moving_cnt, pulse_tgt, moving);
               prev_left = t.pulse_left;
               prev_right = t.pulse_right;
               since_start = t.now_ms - start_ms;
               if (steady_cnt >= pres_tgt && (calm_cnt >= gyro_tgt || moving_cnt >= pulse_tgt))
                  v.outcome = ld_pkg::OUTCOME_LANDED;
               else if (since_start > abort_ms)
                  v.outcome = ld_pkg::OUTCOME_TIMEOUT;
            end
         end
         v.pressure_count = 8'(steady_cnt);
         v.gyro_count     = 8'(calm_cnt);
         v.pulse_count    = 8'(moving_cnt);
         verdict_q.insert(verdict_q.size(), v);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("ERROR at %0t: %s", $time, what);
      endtask

      task check_result(verdict_type got);
         verdict_type want;
         if (verdict_q.size() == 0) begin
            report_mismatch("result item with no tick outstanding");
            return;
         end
         want = verdict_q[0];
         verdict_q.delete(0);
         if (got.outcome !== want.outcome)
            report_mismatch($sformatf("outcome %0d, want %0d", got.outcome, want.outcome));
         if (got.checked !== want.checked)
            report_mismatch($sformatf("checked %0d, want %0d", got.checked, want.checked));
         if (got.pressure_count !== want.pressure_count)
            report_mismatch($sformatf("pressure_count %0d, want %0d",
                                      got.pressure_count, want.pressure_count));
         if (got.gyro_count !== want.gyro_count)
            report_mismatch($sformatf("gyro_count %0d, want %0d",
                                      got.gyro_count, want.gyro_count));
         if (got.pulse_count !== want.pulse_count)
            report_mismatch($sformatf("pulse_count %0d, want %0d",
                                      got.pulse_count, want.pulse_count));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid;
   logic                           req_ready;
   logic                           req_begin_req;
   logic [31:0]                    req_now_ms;
   logic signed [11:0]             req_gyro_x;
   logic signed [11:0]             req_gyro_y;
   logic signed [11:0]             req_gyro_z;
   logic [10:0]                    req_pressure;
   logic signed [31:0]             req_pulse_left;
   logic signed [31:0]             req_pulse_right;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [1:0]                     rsp_outcome;
   logic                           rsp_checked;
   logic [7:0]                     rsp_pressure_count;
   logic [7:0]                     rsp_gyro_count;
   logic [7:0]                     rsp_pulse_count;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [ld_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ld_pkg::CSR_DATA_W-1:0]  csr_data;

   scoreboard_type sb;
   int             ticks_sent = 0;
   bit             sender_eager = 1'b0;
   bit             squeeze_rsp = 1'b0;
   logic [31:0]    clock_ms = '0;
   int             base_pres = 1000;
   int             wheel_left = 0;
   int             wheel_right = 0;

   always #5 clock = ~clock;

   landing_detector dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_begin_req      (req_begin_req),
      .req_now_ms         (req_now_ms),
      .req_gyro_x         (req_gyro_x),
      .req_gyro_y         (req_gyro_y),
      .req_gyro_z         (req_gyro_z),
      .req_pressure       (req_pressure),
      .req_pulse_left     (req_pulse_left),
      .req_pulse_right    (req_pulse_right),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_outcome        (rsp_outcome),
      .rsp_checked        (rsp_checked),
      .rsp_pressure_count (rsp_pressure_count),
      .rsp_gyro_count     (rsp_gyro_count),
      .rsp_pulse_count    (rsp_pulse_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   function automatic tick_type mk_tick(bit start, logic [31:0] now, int gx, int gy, int gz,
                                        int pres, logic [31:0] left, logic [31:0] right);
      tick_type t;
      t.begin_req   = start;
      t.now_ms      = now;
      t.gyro_x      = 12'(gx);
      t.gyro_y      = 12'(gy);
      t.gyro_z      = 12'(gz);
      t.pressure    = 11'(pres);
      t.pulse_left  = left;
      t.pulse_right = right;
      return t;
   endfunction

   function automatic tick_type noise_tick();
      tick_type t;
      t.begin_req   = ($urandom_range(0, 9) == 0);
      t.now_ms      = $urandom;
      t.gyro_x      = 12'($urandom);
      t.gyro_y      = 12'($urandom);
      t.gyro_z      = 12'($urandom);
      t.pressure    = ($urandom_range(0, 7) == 0) ? 11'd0 : 11'($urandom);
      t.pulse_left  = $urandom;
      t.pulse_right = $urandom;
      return t;
   endfunction

   function automatic logic signed [11:0] near_zero(int span);
      int v;
      v = int'($urandom_range(0, 2 * span)) - span;
      if (v > 2047) v = 2047;
      if (v < -2048) v = -2048;
      return 12'(v);
   endfunction

   function automatic int wheel_step();
      int d;
      d = int'($urandom_range(0, 2 * sb.pulse_thr + 2));
      if ($urandom_range(0, 4) == 0) d = int'($urandom_range(0, sb.pulse_thr));
      if ($urandom_range(0, 7) == 0) d = -d;
      return d;
   endfunction

   function automatic int sender_gap();
      int pick;
      if (sender_eager) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // called at a rising edge; returns at the edge where the item is taken
   task automatic send_tick(tick_type t);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_begin_req   <= t.begin_req;
      req_now_ms      <= t.now_ms;
      req_gyro_x      <= t.gyro_x;
      req_gyro_y      <= t.gyro_y;
      req_gyro_z      <= t.gyro_z;
      req_pressure    <= t.pressure;
      req_pulse_left  <= t.pulse_left;
      req_pulse_right <= t.pulse_right;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_tick(t);
      ticks_sent++;
   endtask

   task automatic write_csr(ld_pkg::csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_profile(profile_type prof);
      logic [31:0] g_thr, g_tgt, p_thr, p_tgt, w_thr, w_tgt, abort_ms;
      unique case (prof)
         PROF_FLOOR: begin
            g_thr = 0; g_tgt = 1; p_thr = 0; p_tgt = 1; w_thr = 0; w_tgt = 1; abort_ms = 0;
         end
         PROF_CEILING: begin
            g_thr = 2047; g_tgt = 255; p_thr = 2047; p_tgt = 255;
            w_thr = 65535; w_tgt = 255; abort_ms = 32'hFFFF_FFFF;
         end
         PROF_REALISTIC, PROF_LOWERED: begin
            g_thr = $urandom_range(3, 60);
            p_thr = $urandom_range(1, 6);
            w_thr = $urandom_range(50, 3000);
            abort_ms = $urandom_range(3000, 60000);
            g_tgt = $urandom_range(2, 8);
            p_tgt = $urandom_range(2, 8);
            w_tgt = $urandom_range(2, 8);
            if (prof == PROF_LOWERED) begin
               g_tgt = $urandom_range(1, 2);
               p_tgt = $urandom_range(1, 2);
               w_tgt = $urandom_range(1, 2);
            end
         end
         PROF_ANY: begin
            g_thr = $urandom_range(0, 2047);
            g_tgt = $urandom_range(1, 255);
            p_thr = $urandom_range(0, 2047);
            p_tgt = $urandom_range(1, 255);
            w_thr = $urandom_range(0, 65535);
            w_tgt = $urandom_range(1, 255);
            abort_ms = $urandom;
         end
         default: begin
            g_thr = ld_pkg::GYRO_THRESHOLD_RST; g_tgt = ld_pkg::GYRO_COUNT_TARGET_RST;
            p_thr = ld_pkg::PRES_DELTA_THRESH_RST; p_tgt = ld_pkg::PRES_COUNT_TARGET_RST;
            w_thr = ld_pkg::PULSE_THRESHOLD_RST; w_tgt = ld_pkg::PULSE_COUNT_TARGET_RST;
            abort_ms = ld_pkg::ABORT_TIME_MS_RST;
         end
      endcase
      write_csr(ld_pkg::CSR_GYRO_THRESHOLD, g_thr);
      write_csr(ld_pkg::CSR_GYRO_COUNT_TARGET, g_tgt);
      write_csr(ld_pkg::CSR_PRES_DELTA_THRESH, p_thr);
      write_csr(ld_pkg::CSR_PRES_COUNT_TARGET, p_tgt);
      write_csr(ld_pkg::CSR_PULSE_THRESHOLD, w_thr);
      write_csr(ld_pkg::CSR_PULSE_COUNT_TARGET, w_tgt);
      write_csr(ld_pkg::CSR_ABORT_TIME_MS, abort_ms);
      csr_valid <= 1'b0;
   endtask

   // one descent: a begin item (unless continuing), then plausible sensor ticks mixed with random noise ticks
   task automatic fly(int n_ticks, bit fresh);
      tick_type t;
      int       k, span, p;
      if (fresh) begin
         t = noise_tick();
         t.begin_req = 1'b1;
         if ($urandom_range(0, 4) == 0) t.now_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
         clock_ms = t.now_ms;
         base_pres = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 2047);
         send_tick(t);
      end
      for (k = 0; k < n_ticks; k++) begin
         if ($urandom_range(0, 19) == 0) begin
            send_tick(noise_tick());
            continue;
         end
         clock_ms += ($urandom_range(0, 9) == 0) ? $urandom_range(700, 5000)
                                                 : $urandom_range(50, 700);
         span = sb.gyro_thr + 1;
         if ($urandom_range(0, 4) == 0) span = 2048;
         t.begin_req = 1'b0;
         t.now_ms = clock_ms;
         t.gyro_x = near_zero(span);
         t.gyro_y = near_zero(span);
         t.gyro_z = near_zero(span);
         if ($urandom_range(0, 9) == 0)
            base_pres = base_pres + int'($urandom_range(0, 100)) - 50;
         if (base_pres < 0) base_pres = 0;
         if (base_pres > 2047) base_pres = 2047;
         span = sb.pres_thr + 1;
         p = base_pres + int'($urandom_range(0, 2 * span)) - span;
         if (p < 0) p = 0;
         if (p > 2047) p = 2047;
         t.pressure = 11'(p);
         wheel_left += wheel_step();
         wheel_right += wheel_step();
         t.pulse_left = wheel_left;
         t.pulse_right = wheel_right;
         send_tick(t);
      end
   endtask

   initial begin : stimulus
      profile_type plan [8];
      int          phase_stop;
      int          k;
      plan = '{PROF_REALISTIC, PROF_LOWERED, PROF_FLOOR, PROF_REALISTIC,
               PROF_CEILING, PROF_ANY, PROF_DEFAULT, PROF_REALISTIC};
      sb = new();
      req_valid = 1'b0;
      req_begin_req = 1'b0;
      req_now_ms = '0;
      req_gyro_x = '0;
      req_gyro_y = '0;
      req_gyro_z = '0;
      req_pressure = '0;
      req_pulse_left = '0;
      req_pulse_right = '0;
      csr_valid = 1'b0;
      csr_index = ld_pkg::CSR_GYRO_THRESHOLD;
      csr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part, register defaults
      send_tick(mk_tick(0, 32'd0, 0, 0, 0, 0, 32'd0, 32'd0));
      send_tick(mk_tick(0, 32'd1000, 2047, -2048, 0, 2047, 32'h7FFF_FFFF, 32'h8000_0000));
      send_tick(mk_tick(0, 32'd1500, -2048, 2047, -1, 0, 32'd5, 32'hFFFF_FFFB));
      send_tick(mk_tick(0, 32'd2000, 4, -4, 4, 0, 32'h8000_0000, 32'h7FFF_FFFF));
      // begin near the time wrap, junk in the other fields
      send_tick(mk_tick(1, 32'hFFFF_FC00, -2048, 2047, -2048, 2047,
                        32'hFFFF_FFFF, 32'h0000_0000));
      // steady pressure and calm gyro across the wrap: lands, then counters saturate
      for (k = 1; k <= 6; k++)
         send_tick(mk_tick(0, 32'hFFFF_FC00 + k * 1000, 0, 1, -1, 1013,
                           32'h8000_0000, 32'h7FFF_FFFF));
      // abort boundary, check interval boundary, thresholds exactly met
      send_tick(mk_tick(1, 32'h0010_0000, 0, 0, 0, 900, 32'h8000_0000, 32'h7FFF_FFFF));
      send_tick(mk_tick(0, 32'h0010_0000 + 600000, 5, -5, 5, 900,
                        32'h8000_03E9, 32'h7FFF_FC16));
      send_tick(mk_tick(0, 32'h0010_0000 + 600999, 0, 0, 0, 900,
                        32'h8000_03E9, 32'h7FFF_FC16));
      send_tick(mk_tick(0, 32'h0010_0000 + 601000, 0, 0, 0, 901,
                        32'h8000_07D1, 32'h7FFF_F82E));

      foreach (plan[i]) begin
         drain();
         apply_profile(plan[i]);
         sender_eager = (i == 3 || i == 6);
         if (i == 3) squeeze_rsp = 1'b1;
         phase_stop = ticks_sent + 215;
         // lowered targets: continue the descent so held counters show up
         fly($urandom_range(5, 40), plan[i] != PROF_LOWERED);
         while (ticks_sent < phase_stop)
            fly($urandom_range(5, 40), $urandom_range(0, 2) != 0);
      end

      drain();
      repeat (6) @(posedge clock);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : rsp_side
      int run, pick;
      bit level;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (squeeze_rsp) begin
            // long hold-off so the pipe fills and req_ready drops
            level = 1'b0;
            run = 300;
            squeeze_rsp = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               level = 1'b1; run = $urandom_range(1, 12);
            end else if (pick < 63) begin
               level = 1'b1; run = $urandom_range(40, 200);
            end else if (pick < 90) begin
               level = 1'b0; run = $urandom_range(1, 3);
            end else begin
               level = 1'b0; run = $urandom_range(4, 30);
            end
         end
         repeat (run) begin
            rsp_ready <= level;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      verdict_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.outcome        = ld_pkg::outcome_type'(rsp_outcome);
         got.checked        = rsp_checked;
         got.pressure_count = rsp_pressure_count;
         got.gyro_count     = rsp_gyro_count;
         got.pulse_count    = rsp_pulse_count;
         sb.check_result(got);
      end
   end

   initial begin : watchdog
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
